@@ design/mfrs_pkg.sv @@
// shared types and constants of the multi-fault record scanner
// no dependencies; imported by every other design file
`default_nettype none

package mfrs_pkg;

    localparam int OP_W     = 2;
    localparam int RRID_W   = 6;
    localparam int SVI_W    = 12;
    localparam int SVW_W    = 16;
    localparam int CNT_W    = 7;
    localparam int WCNT_W   = 4;
    localparam int WIDX_W   = 3;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DAT_W = 7;

    localparam logic [OP_W-1:0] OP_RECORD = 2'd0;
    localparam logic [OP_W-1:0] OP_READ   = 2'd1;
    localparam logic [OP_W-1:0] OP_WRITE  = 2'd2;
    localparam logic [OP_W-1:0] OP_CLEAR  = 2'd3;

    localparam logic [CFG_IDX_W-1:0] CFG_MFR_EN   = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_RRID_CNT = 1'b1;

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_MOD  = 5'b00010,
        S_SCAN = 5'b00100,
        S_DONE = 5'b01000,
        S_OUT  = 5'b10000
    } state_t;

    typedef struct packed {
        logic              set_en;
        logic [RRID_W-1:0] set_idx;
        logic              clr_all;
        logic              clr_win;
        logic [WIDX_W-1:0] win;
    } bm_ctrl_t;

endpackage

`default_nettype wire

@@ design/mfrs_in_if.sv @@
// input channel of the scanner: valid/ready handshake and the request payload
// depends on mfrs_pkg
`default_nettype none

interface mfrs_in_if;
    import mfrs_pkg::*;

    logic              valid;
    logic              ready;
    logic [OP_W-1:0]   operation;
    logic [RRID_W-1:0] rrid;
    logic [SVI_W-1:0]  svi_value;

    modport source (output valid, output operation, output rrid, output svi_value,
                    input ready);
    modport sink   (input valid, input operation, input rrid, input svi_value,
                    output ready);
endinterface

`default_nettype wire

@@ design/mfrs_out_if.sv @@
// result channel of the scanner: valid/ready handshake and the result payload
// depends on mfrs_pkg
`default_nettype none

interface mfrs_out_if;
    import mfrs_pkg::*;

    logic             valid;
    logic             ready;
    logic             svs;
    logic [SVW_W-1:0] svw;
    logic [SVI_W-1:0] svi_out;
    logic             svc;

    modport source (output valid, output svs, output svw, output svi_out, output svc,
                    input ready);
    modport sink   (input valid, input svs, input svw, input svi_out, input svc,
                    output ready);
endinterface

`default_nettype wire

@@ design/mfrs_csub.sv @@
// shared conditional subtract unit: a >= m ? a - m : a
// depends on mfrs_pkg; used for the modulo steps and the window wrap
`default_nettype none

module mfrs_csub (
    input  wire logic [mfrs_pkg::WCNT_W-1:0] a,
    input  wire logic [mfrs_pkg::WCNT_W-1:0] m,
    output logic      [mfrs_pkg::WCNT_W-1:0] y
);
    import mfrs_pkg::*;

    assign y = (a >= m) ? (a - m) : a;
endmodule

`default_nettype wire

@@ design/mfrs_bitmap.sv @@
// violation bitmap: bit set, whole clear, window extract and window clear
// depends on mfrs_pkg (bm_ctrl_t)
`default_nettype none

module mfrs_bitmap #(
    parameter int BITS = 64
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire mfrs_pkg::bm_ctrl_t            ctrl,
    input  wire logic [mfrs_pkg::CNT_W-1:0]    count,
    output logic      [mfrs_pkg::SVW_W-1:0]    win_bits,
    output logic                               any
);
    import mfrs_pkg::*;

    localparam int IW = (BITS > 1) ? $clog2(BITS) : 1;

    logic [BITS-1:0]  bm_reg;
    logic [SVW_W-1:0] win_mask;
    logic [CNT_W-1:0] idx [SVW_W];

    // bit j of the window is requester win*16+j, valid below the count and the bitmap size
    always_comb
    begin
        for (int j = 0; j < SVW_W; j++)
        begin
            idx[j]      = {ctrl.win, 4'(j)};
            win_mask[j] = (idx[j] < count) && (idx[j] < CNT_W'(BITS));
            win_bits[j] = win_mask[j] & bm_reg[idx[j][IW-1:0]];
        end
    end

    assign any = |bm_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bm_reg <= '0;
        end
        else if (ctrl.clr_all)
        begin
            bm_reg <= '0;
        end
        else
        begin
            if (ctrl.set_en && ({1'b0, ctrl.set_idx} < CNT_W'(BITS)))
            begin
                bm_reg[ctrl.set_idx[IW-1:0]] <= 1'b1;
            end
            if (ctrl.clr_win)
            begin
                for (int j = 0; j < SVW_W; j++)
                begin
                    if (win_mask[j])
                    begin
                        bm_reg[idx[j][IW-1:0]] <= 1'b0;
                    end
                end
            end
        end
    end
endmodule

`default_nettype wire

@@ design/multi_fault_record_scanner.sv @@
// sequence, input beat to result beat: record, write index, clear and a read with the record
//   disabled or no windows go straight to the result state; a scanning read runs the
//   bit-serial index modulo window count, then tries windows in turn (up to 8), then a
//   pending update state when a window is found, and no update when every window is empty
// throughput: one item at a time, next input beat taken the cycle after the result beat;
//   the modulo and the scan take turns on the shared conditional subtract unit
// reset: bitmap, scan index and pending flag clear; mfr_enable = 1, rrid_count = 64
`default_nettype none

module multi_fault_record_scanner #(
    parameter int RRID_MAX = 64
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              cfg_we,
    input  wire logic [mfrs_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [mfrs_pkg::CFG_DAT_W-1:0]    cfg_wdata,
    mfrs_in_if.sink                                in_ch,
    mfrs_out_if.source                             out_ch
);
    import mfrs_pkg::*;

    // usable requester count is capped by RRID_MAX and by the count register width
    localparam int CAP     = (RRID_MAX < 127) ? RRID_MAX : 127;
    // only ids reachable through the 6-bit rrid field need storage
    localparam int BM_BITS = (RRID_MAX < 64) ? RRID_MAX : 64;

    state_t             state_reg;
    logic               en_reg;
    logic [CNT_W-1:0]   cnt_reg;
    logic [SVI_W-1:0]   scan_index_reg;
    logic               pending_reg;
    logic [WCNT_W-1:0]  cur_reg;      // remainder during modulo, window during scan
    logic [WCNT_W-1:0]  start_reg;
    logic [WCNT_W-1:0]  k_reg;        // windows tried so far
    logic [WCNT_W-1:0]  step_reg;     // modulo step count
    logic [SVI_W-1:0]   sh_reg;       // index bits fed msb first into the modulo
    logic               svs_reg;
    logic [SVW_W-1:0]   svw_reg;
    logic [SVI_W-1:0]   svi_reg;

    logic [CNT_W-1:0]   eff;
    logic [CNT_W:0]     win_sum;
    logic [WCNT_W-1:0]  win;
    logic [WCNT_W-1:0]  csub_a;
    logic [WCNT_W-1:0]  csub_y;
    logic               accept;
    bm_ctrl_t           bm_ctrl;
    logic [SVW_W-1:0]   win_bits;
    logic               bm_any;

    // effective count and window count, ceil(count / 16)
    assign eff     = (cnt_reg > CNT_W'(CAP)) ? CNT_W'(CAP) : cnt_reg;
    assign win_sum = {1'b0, eff} + (CNT_W+1)'(15);
    assign win     = win_sum[CNT_W:4];

    assign accept       = in_ch.valid && in_ch.ready;
    assign in_ch.ready  = (state_reg == S_IDLE);
    assign out_ch.valid = (state_reg == S_OUT);
    assign out_ch.svs     = svs_reg;
    assign out_ch.svw     = svw_reg;
    assign out_ch.svi_out = svi_reg;
    assign out_ch.svc     = pending_reg;

    // shared unit: modulo step shifts in the next index bit, scan step wraps the window
    assign csub_a = (state_reg == S_MOD) ? {cur_reg[WCNT_W-2:0], sh_reg[SVI_W-1]}
                                         : (cur_reg + WCNT_W'(1));

    mfrs_csub u_csub (
        .a (csub_a),
        .m (win),
        .y (csub_y)
    );

    always_comb
    begin
        bm_ctrl.set_en  = accept && (in_ch.operation == OP_RECORD)
                          && ({1'b0, in_ch.rrid} < eff);
        bm_ctrl.set_idx = in_ch.rrid;
        bm_ctrl.clr_all = accept && (in_ch.operation == OP_CLEAR);
        bm_ctrl.clr_win = (state_reg == S_SCAN) && (win_bits != '0);
        bm_ctrl.win     = cur_reg[WIDX_W-1:0];
    end

    mfrs_bitmap #(
        .BITS (BM_BITS)
    ) u_bitmap (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctrl     (bm_ctrl),
        .count    (eff),
        .win_bits (win_bits),
        .any      (bm_any)
    );

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            en_reg  <= 1'b1;
            cnt_reg <= CNT_W'(64);
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_MFR_EN:   en_reg  <= cfg_wdata[0];
                CFG_RRID_CNT: cnt_reg <= cfg_wdata[CNT_W-1:0];
                default:      ;
            endcase
        end
    end

    // sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            scan_index_reg <= '0;
            pending_reg    <= 1'b0;
            cur_reg        <= '0;
            start_reg      <= '0;
            k_reg          <= '0;
            step_reg       <= '0;
            sh_reg         <= '0;
            svs_reg        <= 1'b0;
            svw_reg        <= '0;
            svi_reg        <= '0;
        end
        else
        begin
            case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        svs_reg <= 1'b0;
                        svw_reg <= '0;
                        case (in_ch.operation)
                            OP_RECORD:
                            begin
                                if (bm_ctrl.set_en)
                                begin
                                    pending_reg <= 1'b1;
                                end
                                svi_reg   <= scan_index_reg;
                                state_reg <= S_OUT;
                            end
                            OP_WRITE:
                            begin
                                scan_index_reg <= in_ch.svi_value;
                                svi_reg        <= in_ch.svi_value;
                                state_reg      <= S_OUT;
                            end
                            OP_CLEAR:
                            begin
                                pending_reg <= 1'b0;
                                svi_reg     <= scan_index_reg;
                                state_reg   <= S_OUT;
                            end
                            OP_READ:
                            begin
                                if (!en_reg || (win == '0))
                                begin
                                    svi_reg   <= '0;
                                    state_reg <= S_OUT;
                                end
                                else
                                begin
                                    cur_reg   <= '0;
                                    step_reg  <= '0;
                                    sh_reg    <= scan_index_reg;
                                    state_reg <= S_MOD;
                                end
                            end
                            default:
                            begin
                                state_reg <= S_OUT;
                            end
                        endcase
                    end
                end
                S_MOD:
                begin
                    // restoring remainder, one index bit per cycle
                    cur_reg  <= csub_y;
                    sh_reg   <= {sh_reg[SVI_W-2:0], 1'b0};
                    step_reg <= step_reg + WCNT_W'(1);
                    if (step_reg == WCNT_W'(SVI_W - 1))
                    begin
                        start_reg <= csub_y;
                        k_reg     <= '0;
                        state_reg <= S_SCAN;
                    end
                end
                S_SCAN:
                begin
                    if (win_bits != '0)
                    begin
                        // window is cleared by the bitmap in this same cycle
                        scan_index_reg <= SVI_W'(cur_reg);
                        svs_reg        <= 1'b1;
                        svw_reg        <= win_bits;
                        svi_reg        <= SVI_W'(cur_reg);
                        state_reg      <= S_DONE;
                    end
                    else if (k_reg == (win - WCNT_W'(1)))
                    begin
                        // nothing logged in any window
                        svi_reg   <= SVI_W'(start_reg);
                        state_reg <= S_OUT;
                    end
                    else
                    begin
                        k_reg   <= k_reg + WCNT_W'(1);
                        cur_reg <= csub_y;
                    end
                end
                S_DONE:
                begin
                    // pending drops once the whole bitmap is empty
                    if (!bm_any)
                    begin
                        pending_reg <= 1'b0;
                    end
                    state_reg <= S_OUT;
                end
                S_OUT:
                begin
                    if (out_ch.ready)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end
endmodule

`default_nettype wire

@@ tb/tb_multi_fault_record_scanner.sv @@
`timescale 1ns / 100ps
// self-checking bench for multi_fault_record_scanner: directed and random request beats
// depends on mfrs_pkg, mfrs_in_if, mfrs_out_if and the scanner itself

module tb_multi_fault_record_scanner;
    import mfrs_pkg::*;

    localparam int LOG_DEPTH  = 64;
    localparam int WIN_SIZE   = 16;
    localparam int HOLD_BEATS = 300;

    // one expected result beat
    typedef struct packed {
        logic             svs;
        logic [SVW_W-1:0] svw;
        logic [SVI_W-1:0] svi;
        logic             svc;
    } scan_report_t;

    // shadow of the fault log plus the queue of reports still owed by the block
    class fault_log_scoreboard;
        bit [LOG_DEPTH-1:0] vio_bits;
        bit [SVI_W-1:0]     scan_idx;
        bit                 pend;
        bit                 mfr_en;
        bit [CNT_W-1:0]     rrid_cnt;
        scan_report_t       due_reports[$];
        int                 mismatches;

        function new();
            vio_bits   = '0;
            scan_idx   = '0;
            pend       = 1'b0;
            mfr_en     = 1'b1;
            rrid_cnt   = CNT_W'(LOG_DEPTH);
            mismatches = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] val);
            if (idx == CFG_MFR_EN)
                mfr_en = val[0];
            else
                rrid_cnt = val[CNT_W-1:0];
        endfunction

        function int live_count();
            return (rrid_cnt > LOG_DEPTH) ? LOG_DEPTH : int'(rrid_cnt);
        endfunction

        // advance the shadow log by one request and return the report it produces
        function scan_report_t apply_request(logic [OP_W-1:0] op, logic [RRID_W-1:0] id,
                                             logic [SVI_W-1:0] sv);
            scan_report_t     rep;
            int               cnt;
            int               windows;
            int               first_win;
            int               w;
            int               r;
            bit [SVW_W-1:0]   win_bits;
            cnt = live_count();
            rep = '0;
            case (op)
                OP_RECORD:
                begin
                    if (id < cnt)
                    begin
                        vio_bits[id] = 1'b1;
                        pend = 1'b1;
                    end
                    rep.svi = scan_idx;
                end
                OP_WRITE:
                begin
                    scan_idx = sv;
                    rep.svi = scan_idx;
                end
                OP_CLEAR:
                begin
                    vio_bits = '0;
                    pend = 1'b0;
                    rep.svi = scan_idx;
                end
                default:
                begin
                    windows = (cnt + WIN_SIZE - 1) / WIN_SIZE;
                    if (mfr_en && windows != 0)
                    begin
                        first_win = scan_idx % windows;
                        rep.svi = SVI_W'(first_win);
                        for (int k = 0; k < windows && !rep.svs; k++)
                        begin
                            w = (first_win + k) % windows;
                            win_bits = '0;
                            for (int j = 0; j < WIN_SIZE; j++)
                            begin
                                r = w * WIN_SIZE + j;
                                if (r < cnt && vio_bits[r])
                                    win_bits[j] = 1'b1;
                            end
                            if (win_bits != '0)
                            begin
                                for (int j = 0; j < WIN_SIZE; j++)
                                begin
                                    r = w * WIN_SIZE + j;
                                    if (r < cnt)
                                        vio_bits[r] = 1'b0;
                                end
                                scan_idx = SVI_W'(w);
                                if (vio_bits == '0)
                                    pend = 1'b0;
                                rep.svs = 1'b1;
                                rep.svw = win_bits;
                                rep.svi = SVI_W'(w);
                            end
                        end
                    end
                end
            endcase
            rep.svc = pend;
            return rep;
        endfunction

        function void note_request(logic [OP_W-1:0] op, logic [RRID_W-1:0] id,
                                   logic [SVI_W-1:0] sv);
            due_reports.push_back(apply_request(op, id, sv));
        endfunction

        function void check_report(logic svs, logic [SVW_W-1:0] svw,
                                   logic [SVI_W-1:0] svi, logic svc);
            scan_report_t want;
            if (due_reports.size() == 0)
            begin
                $error("result beat with no request outstanding");
                mismatches++;
                return;
            end
            want = due_reports.pop_front();
            if (svs !== want.svs)
            begin
                $error("svs mismatch: expected %0d, actual %0d", want.svs, svs);
                mismatches++;
            end
            if (svw !== want.svw)
            begin
                $error("svw mismatch: expected %h, actual %h", want.svw, svw);
                mismatches++;
            end
            if (svi !== want.svi)
            begin
                $error("svi_out mismatch: expected %0d, actual %0d", want.svi, svi);
                mismatches++;
            end
            if (svc !== want.svc)
            begin
                $error("svc mismatch: expected %0d, actual %0d", want.svc, svc);
                mismatches++;
            end
        endfunction
    endclass

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DAT_W-1:0]  cfg_wdata;

    mfrs_in_if  in_ch();
    mfrs_out_if out_ch();

    fault_log_scoreboard sb;

    // idling knobs, percent of cycles spent idle; changed per phase
    int send_pct;
    int stall_pct;
    int sent_items;
    int rx_cycles;
    // long receiver hold-off, requested by the stimulus and counted down by the receiver
    bit hold_req;
    int hold_left;

    multi_fault_record_scanner #(
        .RRID_MAX (LOG_DEPTH)
    ) u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .in_ch     (in_ch),
        .out_ch    (out_ch)
    );

    // 2 ns clock
    initial
    begin
        clk = 1'b0;
    end

    always #1 clk = ~clk;

    // all inputs known from time zero
    initial
    begin
        rst_n            = 1'b0;
        cfg_we           = 1'b0;
        cfg_index        = '0;
        cfg_wdata        = '0;
        in_ch.valid      = 1'b0;
        in_ch.operation  = OP_RECORD;
        in_ch.rrid       = '0;
        in_ch.svi_value  = '0;
        out_ch.ready     = 1'b0;
        send_pct         = 0;
        stall_pct        = 0;
        sent_items       = 0;
        rx_cycles        = 0;
        hold_req         = 1'b0;
        hold_left        = 0;
    end

    // receiver: random stalls, with recurring stall-free stretches,
    // and the occasional long hold-off so the block backs up into its input
    always @(negedge clk)
    begin
        rx_cycles++;
        if (hold_req)
        begin
            hold_left = HOLD_BEATS;
            hold_req  = 1'b0;
        end
        if (hold_left > 0)
        begin
            out_ch.ready <= 1'b0;
            hold_left--;
        end
        else if ((rx_cycles % 128) < 32)
            out_ch.ready <= 1'b1;
        else
            out_ch.ready <= ($urandom_range(0, 99) >= stall_pct);
    end

    // every beat and register write is seen here at the rising edge
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (cfg_we)
                sb.write_reg(cfg_index, cfg_wdata);
            if (in_ch.valid && in_ch.ready)
                sb.note_request(in_ch.operation, in_ch.rrid, in_ch.svi_value);
            if (out_ch.valid && out_ch.ready)
                sb.check_report(out_ch.svs, out_ch.svw, out_ch.svi_out, out_ch.svc);
        end
    end

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] val);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(negedge clk);
        cfg_we    <= 1'b0;
    endtask

    // offer one request beat and hold it until the block takes it;
    // valid stays high afterwards so back-to-back beats need no toggle
    task automatic send_request(logic [OP_W-1:0] op, logic [RRID_W-1:0] id,
                                logic [SVI_W-1:0] sv);
        int pct;
        pct = ((sent_items % 64) < 16) ? 0 : send_pct;
        @(negedge clk);
        while ($urandom_range(0, 99) < pct)
        begin
            in_ch.valid <= 1'b0;
            @(negedge clk);
        end
        in_ch.valid     <= 1'b1;
        in_ch.operation <= op;
        in_ch.rrid      <= id;
        in_ch.svi_value <= sv;
        sent_items++;
        do
            @(posedge clk);
        while (in_ch.ready !== 1'b1);
    endtask

    // lower valid, let every owed report come back, then give the block time to settle
    task automatic drain_block();
        @(negedge clk);
        in_ch.valid <= 1'b0;
        while (sb.due_reports.size() != 0)
            @(posedge clk);
        repeat (30) @(posedge clk);
    endtask

    // mostly records and reads aimed at the live requester range, so windows fill
    // up and scans actually find something; writes and clears mixed in
    task automatic random_request();
        int               cnt;
        int               roll;
        logic [OP_W-1:0]  op;
        logic [RRID_W-1:0] id;
        logic [SVI_W-1:0] sv;
        cnt  = sb.live_count();
        roll = $urandom_range(0, 99);
        if (roll < 50)
            op = OP_RECORD;
        else if (roll < 84)
            op = OP_READ;
        else if (roll < 95)
            op = OP_WRITE;
        else
            op = OP_CLEAR;
        if (cnt > 0 && $urandom_range(0, 3) != 0)
            id = RRID_W'($urandom_range(0, cnt - 1));
        else
            id = RRID_W'($urandom_range(0, 63));
        if ($urandom_range(0, 3) != 0)
            sv = SVI_W'($urandom_range(0, 7));
        else
            sv = SVI_W'($urandom);
        send_request(op, id, sv);
    endtask

    // one random phase: block idle, new register settings, new idling mix
    task automatic run_phase(logic en, logic [CNT_W-1:0] cnt, int sp, int rp, int beats,
                             bit squeeze);
        drain_block();
        write_reg(CFG_MFR_EN, CFG_DAT_W'(en));
        write_reg(CFG_RRID_CNT, CFG_DAT_W'(cnt));
        send_pct  = sp;
        stall_pct = rp;
        if (squeeze)
            hold_req = 1'b1;
        repeat (beats) random_request();
    endtask

    initial
    begin
        sb = new();
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // directed, reset settings: 64 requesters, four windows
        // edges of the id range and of window boundaries
        send_request(OP_RECORD, 6'd0, 12'd0);
        send_request(OP_RECORD, 6'd63, 12'd0);
        send_request(OP_RECORD, 6'd15, 12'd0);
        send_request(OP_RECORD, 6'd16, 12'd0);
        // successive reads walk the windows and store the found index
        send_request(OP_READ, 6'd0, 12'd0);
        send_request(OP_READ, 6'd0, 12'd0);
        send_request(OP_READ, 6'd0, 12'd0);
        // nothing left: empty scan keeps the index
        send_request(OP_READ, 6'd0, 12'd0);
        // stored index beyond the window count, scan wraps round to window two
        send_request(OP_WRITE, 6'd0, 12'hFFF);
        send_request(OP_RECORD, 6'd47, 12'd0);
        send_request(OP_READ, 6'd0, 12'd0);
        // clear drops the pending flag and keeps the index
        send_request(OP_RECORD, 6'd5, 12'd0);
        send_request(OP_CLEAR, 6'd0, 12'd0);
        send_request(OP_READ, 6'd0, 12'd0);
        send_request(OP_WRITE, 6'h3F, 12'd0);
        // left behind on purpose for the lowered count below
        send_request(OP_RECORD, 6'd60, 12'd0);

        // lowered count: 17 requesters, two windows, bit 60 now out of reach
        drain_block();
        write_reg(CFG_RRID_CNT, CFG_DAT_W'(17));
        // out-of-range record is dropped
        send_request(OP_RECORD, 6'd20, 12'd0);
        send_request(OP_RECORD, 6'd16, 12'd0);
        send_request(OP_RECORD, 6'd3, 12'd0);
        // pending stays up because of the stranded bit 60
        send_request(OP_READ, 6'd0, 12'd0);
        send_request(OP_READ, 6'd0, 12'd0);
        send_request(OP_READ, 6'd0, 12'd0);
        send_request(OP_CLEAR, 6'd0, 12'd0);

        // random phases, covering the register extremes and every idling mix;
        // the first one also squeezes the block with a long receiver hold-off
        run_phase(1'b1, 7'd64, 0, 0, 150, 1'b1);
        run_phase(1'b1, 7'd1, 88, 0, 120, 1'b0);
        run_phase(1'b0, 7'd64, 0, 88, 100, 1'b0);
        run_phase(1'b1, 7'd0, 24, 24, 80, 1'b0);
        run_phase(1'b1, 7'd17, 0, 0, 150, 1'b0);
        run_phase(1'b1, 7'd127, 88, 0, 150, 1'b0);
        run_phase(1'b1, 7'd33, 0, 88, 150, 1'b0);
        run_phase(1'b1, 7'd48, 24, 24, 150, 1'b0);
        run_phase(1'b1, 7'd64, 24, 24, 150, 1'b0);

        drain_block();
        if (sb.mismatches == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    // watchdog, far beyond the slowest legal run
    initial
    begin
        #2000000;
        $display("CHECK FAILED");
        $finish;
    end

endmodule

@@ multi_fault_record_scanner.f @@
design/mfrs_pkg.sv
design/mfrs_in_if.sv
design/mfrs_out_if.sv
design/mfrs_csub.sv
design/mfrs_bitmap.sv
design/multi_fault_record_scanner.sv
tb/tb_multi_fault_record_scanner.sv
